// ===== sv/cvkt_pkg.sv =====
package cvkt_pkg;

  // Number of tracked axes; lanes are built for axes below this count.
  localparam int AXES = 3;

  // Configuration port geometry.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Iterations of the restoring divider: a 32-bit magnitude shifted up by 16.
  localparam int DIV_BITS = 48;

  // Multiplies in the prediction and update programs of one lane.
  localparam int PRED_MULS = 10;
  localparam int UPD_MULS  = 6;

  typedef enum logic [2:0] {
    REG_STEP_TIME     = 3'd0,
    REG_NOISE_XY      = 3'd1,
    REG_NOISE_Z       = 3'd2,
    REG_MEAS_NOISE    = 3'd3,
    REG_SPEED_LIMIT   = 3'd4,
    REG_PREDICT_LIMIT = 3'd5,
    REG_STALE_LIMIT   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_PREDICTED = 2'd0,
    ST_RESET     = 2'd1,
    ST_UPDATED   = 2'd2,
    ST_REJECTED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_PREDICT = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_COMMIT  = 2'd2,
    OP_RESTART = 2'd3
  } lane_op_t;

  typedef struct packed {
    logic     start;
    lane_op_t op;
  } lane_cmd_t;

  typedef struct packed {
    logic [16:0] dt;
    logic [23:0] q;
    logic [23:0] r;
  } lane_cfg_t;

  typedef struct packed {
    logic done;
    logic reject;
  } merge_res_t;

  // Sign extension of a 32-bit value to 64 bits.
  function automatic logic signed [63:0] ext64(input logic signed [31:0] x);
    ext64 = {{32{x[31]}}, x};
  endfunction

  // Saturate a 64-bit value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

  // Q16.16 product: round half up at bit 16, then saturate.
  function automatic logic signed [31:0] fround(input logic signed [63:0] p);
    fround = sat32((p + 64'sd32768) >>> 16);
  endfunction

endpackage

// ===== sv/cvkt_in_if.sv =====
interface cvkt_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] meas_x;
  logic signed [31:0] meas_y;
  logic signed [31:0] meas_z;

  modport source(output valid, kind, meas_x, meas_y, meas_z, input ready);
  modport sink(input valid, kind, meas_x, meas_y, meas_z, output ready);
endinterface

// ===== sv/cvkt_out_if.sv =====
interface cvkt_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source(output valid, status, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 input ready);
  modport sink(input valid, status, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               output ready);
endinterface

// ===== sv/cvkt_lane.sv =====
module cvkt_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  cvkt_pkg::lane_cmd_t   cmd,
  input  cvkt_pkg::lane_cfg_t   cfg,
  input  logic signed [31:0]    meas,
  output logic                  busy,
  output logic [63:0]           nv_sq,
  output logic signed [31:0]    pos,
  output logic signed [31:0]    vel
);
  import cvkt_pkg::*;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MUL,
    L_PSUM,
    L_DSETUP,
    L_DIV,
    L_DFIN
  } lane_state_t;

  lane_state_t        state;
  logic signed [31:0] pp, pv, vv;
  logic signed [31:0] rtab [PRED_MULS];
  logic [3:0]         mi;
  logic [1:0]         ph;
  logic               upd;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [31:0] k0, k1, e, s_reg;
  logic [47:0]        dn, quo;
  logic [32:0]        rem;
  logic [5:0]         cnt;
  logic               neg, dsel;

  logic signed [31:0] dt32, q32, r32;
  logic signed [31:0] op_a, op_b;
  logic signed [31:0] nv_c;
  logic signed [31:0] num;
  logic [31:0]        mag;
  logic [32:0]        rem_sh;
  logic               ge;
  logic signed [31:0] qres;
  logic [3:0]         last_mi;

  assign dt32 = {15'd0, cfg.dt};
  assign q32  = {8'd0, cfg.q};
  assign r32  = {8'd0, cfg.r};
  assign nv_c = sat32(ext64(vel) + ext64(rtab[0]));
  assign busy = (state != L_IDLE);
  assign last_mi = upd ? 4'(UPD_MULS - 1) : 4'(PRED_MULS - 1);

  // Operand selection for the shared multiplier, one program per operation.
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (!upd) begin
      case (mi)
        4'd0: begin op_a = dt32;    op_b = dt32;    end
        4'd1: begin op_a = rtab[0]; op_b = dt32;    end
        4'd2: begin op_a = rtab[0]; op_b = rtab[0]; end
        4'd3: begin op_a = dt32;    op_b = vel;     end
        4'd4: begin op_a = dt32;    op_b = pv;      end
        4'd5: begin op_a = rtab[0]; op_b = vv;      end
        4'd6: begin op_a = q32;     op_b = rtab[2]; end
        4'd7: begin op_a = dt32;    op_b = vv;      end
        4'd8: begin op_a = q32;     op_b = rtab[1]; end
        4'd9: begin op_a = q32;     op_b = rtab[0]; end
        default: begin op_a = '0;   op_b = '0;      end
      endcase
    end else begin
      case (mi)
        4'd0: begin op_a = k1;   op_b = e;    end
        4'd1: begin op_a = nv_c; op_b = nv_c; end
        4'd2: begin op_a = k0;   op_b = e;    end
        4'd3: begin op_a = k0;   op_b = pp;   end
        4'd4: begin op_a = k0;   op_b = pv;   end
        4'd5: begin op_a = k1;   op_b = pv;   end
        default: begin op_a = '0; op_b = '0;  end
      endcase
    end
  end

  // Divider datapath: one quotient bit per cycle.
  assign num    = dsel ? pv : pp;
  assign mag    = num[31] ? (~num + 32'd1) : num;
  assign rem_sh = {rem[31:0], dn[47]};
  assign ge     = (rem_sh >= {1'b0, s_reg});

  always_comb begin
    if (neg) begin
      qres = (quo > 48'h0000_8000_0000) ? 32'sh8000_0000 : (~quo[31:0] + 32'd1);
    end else begin
      qres = (quo > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
    end
  end

  // Lane sequencer with the axis state it owns.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      pos   <= '0;
      vel   <= '0;
      pp    <= '0;
      pv    <= '0;
      vv    <= '0;
      mi    <= '0;
      ph    <= '0;
      upd   <= 1'b0;
      dsel  <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (cmd.start) begin
            unique case (cmd.op)
              OP_PREDICT: begin
                upd   <= 1'b0;
                mi    <= '0;
                ph    <= '0;
                state <= L_MUL;
              end
              OP_UPDATE: begin
                upd   <= 1'b1;
                s_reg <= sat32(ext64(pp) + ext64(r32));
                e     <= sat32(ext64(meas) - ext64(pos));
                dsel  <= 1'b0;
                state <= L_DSETUP;
              end
              OP_COMMIT: begin
                pos <= sat32(ext64(pos) + ext64(rtab[2]));
                vel <= nv_c;
                pp  <= sat32(ext64(pp) - ext64(rtab[3]));
                pv  <= sat32(ext64(pv) - ext64(rtab[4]));
                vv  <= sat32(ext64(vv) - ext64(rtab[5]));
              end
              OP_RESTART: begin
                pos <= meas;
                vel <= '0;
                pp  <= '0;
                pv  <= '0;
                vv  <= '0;
              end
              default: ;
            endcase
          end
        end
        L_MUL: begin
          // Issue, multiply, then round and store each product in turn.
          if (ph == 2'd0) begin
            mul_a <= op_a;
            mul_b <= op_b;
            ph    <= 2'd1;
          end else if (ph == 2'd1) begin
            mul_p <= ext64(mul_a) * ext64(mul_b);
            ph    <= 2'd2;
          end else begin
            rtab[mi] <= fround(mul_p);
            if (upd && mi == 4'd1) begin
              nv_sq <= mul_p;
            end
            ph <= 2'd0;
            if (mi == last_mi) begin
              state <= upd ? L_IDLE : L_PSUM;
            end else begin
              mi <= mi + 4'd1;
            end
          end
        end
        L_PSUM: begin
          pos <= sat32(ext64(pos) + ext64(rtab[3]));
          pp  <= sat32(ext64(pp) + (ext64(rtab[4]) <<< 1) + ext64(rtab[5])
                       + ((ext64(rtab[6]) + 64'sd2) >>> 2));
          pv  <= sat32(ext64(pv) + ext64(rtab[7]) + ((ext64(rtab[8]) + 64'sd1) >>> 1));
          vv  <= sat32(ext64(vv) + ext64(rtab[9]));
          state <= L_IDLE;
        end
        L_DSETUP: begin
          if (s_reg <= 32'sd0) begin
            // Non-positive innovation variance gives zero gains.
            k0    <= '0;
            k1    <= '0;
            mi    <= '0;
            ph    <= '0;
            state <= L_MUL;
          end else begin
            neg   <= num[31];
            dn    <= {mag, 16'd0};
            rem   <= '0;
            quo   <= '0;
            cnt   <= '0;
            state <= L_DIV;
          end
        end
        L_DIV: begin
          rem <= ge ? (rem_sh - {1'b0, s_reg}) : rem_sh;
          quo <= {quo[46:0], ge};
          dn  <= {dn[46:0], 1'b0};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DIV_BITS - 1)) begin
            state <= L_DFIN;
          end
        end
        L_DFIN: begin
          if (!dsel) begin
            k0    <= qres;
            dsel  <= 1'b1;
            state <= L_DSETUP;
          end else begin
            k1    <= qres;
            mi    <= '0;
            ph    <= '0;
            state <= L_MUL;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/cvkt_merge.sv =====
module cvkt_merge (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [63:0]            nv_sq [cvkt_pkg::AXES],
  input  logic [23:0]            speed_limit,
  output cvkt_pkg::merge_res_t   res
);
  import cvkt_pkg::*;

  logic [63:0] sum, sum_next;
  logic [47:0] lim;
  logic        stage;

  // Total squared speed over the lanes.
  always_comb begin
    sum_next = '0;
    for (int a = 0; a < AXES; a++) begin
      sum_next = sum_next + nv_sq[a];
    end
  end

  // Register the sum and the squared limit, then compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage    <= 1'b0;
      res.done <= 1'b0;
    end else begin
      stage    <= start;
      res.done <= stage;
      if (start) begin
        sum <= sum_next;
        lim <= speed_limit * speed_limit;
      end
      if (stage) begin
        res.reject <= (sum > {16'd0, lim});
      end
    end
  end

endmodule

// ===== sv/const_velocity_kalman_tracker_core.sv =====
// Three-axis constant-velocity Kalman tracker, Q16.16. One lane per axis holds
// that axis's position, velocity and 2x2 covariance, and steps through its
// work on one shared 32x32 multiplier and one restoring divider (48
// shift-subtract steps a quotient). An item is taken only when the previous
// one has been fully processed. A tick that predicts runs ten products; a
// tick past the predict limit is absorbed in the cycle it is accepted; a stale
// measurement restarts the filter; a gated measurement runs two divisions, six
// products and the speed gate, then the commit unless it is rejected.
// Results sit in an output register, so the next item is accepted while a
// finished result waits to be taken.
// Registers lie at byte address 4*i over the APB-style port.
module const_velocity_kalman_tracker_core (
  input  logic                          clk,
  input  logic                          rst,
  cvkt_in_if.sink                       meas_in,
  cvkt_out_if.source                    result_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvkt_pkg::ADDR_W-1:0]   paddr,
  input  logic [cvkt_pkg::DATA_W-1:0]   pwdata,
  output logic [cvkt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import cvkt_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE,
    T_PRED_GO,
    T_PRED_WAIT,
    T_RESTART,
    T_UPD_GO,
    T_UPD_WAIT,
    T_MERGE,
    T_MERGE_WAIT,
    T_COMMIT,
    T_EMIT
  } top_state_t;

  // Configuration registers.
  logic [16:0] step_time;
  logic [23:0] process_noise_xy, process_noise_z, meas_noise, speed_limit;
  logic [15:0] predict_limit, stale_limit;

  top_state_t         state;
  logic [15:0]        tsu;
  status_t            status;
  logic signed [31:0] meas [3];
  lane_cmd_t          cmd;
  logic               merge_start;
  merge_res_t         mres;
  logic [AXES-1:0]    lane_busy;
  logic [63:0]        lane_nv_sq [AXES];
  logic signed [31:0] lane_pos [AXES];
  logic signed [31:0] lane_vel [AXES];
  logic signed [31:0] pos_all [3];
  logic signed [31:0] vel_all [3];
  logic               in_fire, cfg_wr, out_free;
  reg_idx_t           ridx;

  assign pready   = 1'b1;
  assign ridx     = reg_idx_t'(paddr[4:2]);
  assign cfg_wr   = psel && penable && pwrite;
  assign in_fire  = meas_in.valid && meas_in.ready;
  assign out_free = !result_out.valid || result_out.ready;
  assign meas_in.ready = (state == T_IDLE);

  // Register write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_time        <= 17'd3277;
      process_noise_xy <= 24'd262144;
      process_noise_z  <= 24'd65536;
      meas_noise       <= 24'd6554;
      speed_limit      <= 24'd262144;
      predict_limit    <= 16'd40;
      stale_limit      <= 16'd60;
    end else if (cfg_wr) begin
      unique case (ridx)
        REG_STEP_TIME:     step_time        <= pwdata[16:0];
        REG_NOISE_XY:      process_noise_xy <= pwdata[23:0];
        REG_NOISE_Z:       process_noise_z  <= pwdata[23:0];
        REG_MEAS_NOISE:    meas_noise       <= pwdata[23:0];
        REG_SPEED_LIMIT:   speed_limit      <= pwdata[23:0];
        REG_PREDICT_LIMIT: predict_limit    <= pwdata[15:0];
        REG_STALE_LIMIT:   stale_limit      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (ridx)
      REG_STEP_TIME:     prdata = {15'd0, step_time};
      REG_NOISE_XY:      prdata = {8'd0, process_noise_xy};
      REG_NOISE_Z:       prdata = {8'd0, process_noise_z};
      REG_MEAS_NOISE:    prdata = {8'd0, meas_noise};
      REG_SPEED_LIMIT:   prdata = {8'd0, speed_limit};
      REG_PREDICT_LIMIT: prdata = {16'd0, predict_limit};
      REG_STALE_LIMIT:   prdata = {16'd0, stale_limit};
      default:           prdata = '0;
    endcase
  end

  // Lane commands follow the controller state.
  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = OP_PREDICT;
    unique case (state)
      T_PRED_GO: begin cmd.start = 1'b1; cmd.op = OP_PREDICT; end
      T_RESTART: begin cmd.start = 1'b1; cmd.op = OP_RESTART; end
      T_UPD_GO:  begin cmd.start = 1'b1; cmd.op = OP_UPDATE;  end
      T_COMMIT:  begin cmd.start = 1'b1; cmd.op = OP_COMMIT;  end
      default: ;
    endcase
  end
  assign merge_start = (state == T_MERGE);

  // One lane per axis.
  for (genvar g = 0; g < AXES; g++) begin : g_lane
    lane_cfg_t lcfg;
    assign lcfg.dt = step_time;
    assign lcfg.q  = (g < 2) ? process_noise_xy : process_noise_z;
    assign lcfg.r  = meas_noise;
    cvkt_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .cfg   (lcfg),
      .meas  (meas[g]),
      .busy  (lane_busy[g]),
      .nv_sq (lane_nv_sq[g]),
      .pos   (lane_pos[g]),
      .vel   (lane_vel[g])
    );
  end

  // Axes without a lane report zero.
  for (genvar g = 0; g < 3; g++) begin : g_axis
    if (g < AXES) begin : g_on
      assign pos_all[g] = lane_pos[g];
      assign vel_all[g] = lane_vel[g];
    end else begin : g_off
      assign pos_all[g] = '0;
      assign vel_all[g] = '0;
    end
  end

  cvkt_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .start       (merge_start),
    .nv_sq       (lane_nv_sq),
    .speed_limit (speed_limit),
    .res         (mres)
  );

  // Transaction controller and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= T_IDLE;
      tsu              <= 16'hFFFF;
      status           <= ST_PREDICTED;
      result_out.valid <= 1'b0;
    end else begin
      // In the emit state the output register is reloaded instead.
      if (result_out.valid && result_out.ready && state != T_EMIT) begin
        result_out.valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (in_fire) begin
            meas[0] <= meas_in.meas_x;
            meas[1] <= meas_in.meas_y;
            meas[2] <= meas_in.meas_z;
            if (!meas_in.kind) begin
              if (tsu != 16'hFFFF) begin
                tsu <= tsu + 16'd1;
              end
              if (tsu < predict_limit) begin
                status <= ST_PREDICTED;
                state  <= T_PRED_GO;
              end
            end else if (tsu > stale_limit) begin
              status <= ST_RESET;
              tsu    <= '0;
              state  <= T_RESTART;
            end else begin
              state <= T_UPD_GO;
            end
          end
        end
        T_PRED_GO:   state <= T_PRED_WAIT;
        T_PRED_WAIT: if (lane_busy == '0) state <= T_EMIT;
        T_RESTART:   state <= T_EMIT;
        T_UPD_GO:    state <= T_UPD_WAIT;
        T_UPD_WAIT:  if (lane_busy == '0) state <= T_MERGE;
        T_MERGE:     state <= T_MERGE_WAIT;
        T_MERGE_WAIT: begin
          if (mres.done) begin
            if (mres.reject) begin
              status <= ST_REJECTED;
              state  <= T_EMIT;
            end else begin
              status <= ST_UPDATED;
              tsu    <= '0;
              state  <= T_COMMIT;
            end
          end
        end
        T_COMMIT: state <= T_EMIT;
        T_EMIT: begin
          if (out_free) begin
            result_out.valid  <= 1'b1;
            result_out.status <= status;
            result_out.pos_x  <= pos_all[0];
            result_out.pos_y  <= pos_all[1];
            result_out.pos_z  <= pos_all[2];
            result_out.vel_x  <= vel_all[0];
            result_out.vel_y  <= vel_all[1];
            result_out.vel_z  <= vel_all[2];
            state             <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A tick past the predict limit is absorbed without leaving idle.
  a_late_tick: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !meas_in.kind && tsu >= predict_limit) |=> state == T_IDLE)
    else $error("late tick started work");

  // A stale measurement always restarts the lanes.
  a_stale: assert property (@(posedge clk) disable iff (rst)
    (in_fire && meas_in.kind && tsu > stale_limit) |=> state == T_RESTART)
    else $error("stale measurement did not restart");

  // An updated result only leaves with the tick counter cleared.
  a_upd_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == T_EMIT && out_free && status == ST_UPDATED) |=> tsu == 16'd0)
    else $error("update emitted without clearing tick count");

  // Lanes are never busy when the controller is idle.
  a_lane_idle: assert property (@(posedge clk) disable iff (rst)
    (state == T_IDLE) |-> (lane_busy == '0))
    else $error("lane busy while controller idle");
`endif

endmodule

// ===== tb/sv/cvkt_tracker_checker.sv =====
// Watches the measurement, result and register channels of the tracker, keeps its own
// copy of the filter state and compares every result transaction with the predicted one.
module cvkt_tracker_checker (
  input  logic        clk,
  input  logic        rst,
  cvkt_in_if          mon_in,
  cvkt_out_if         mon_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [cvkt_pkg::ADDR_W-1:0] paddr,
  input  logic [cvkt_pkg::DATA_W-1:0] pwdata,
  input  logic        pready,
  output int          errors,
  output int          pending
);
  import cvkt_pkg::*;

  typedef struct {
    status_t status;
    int      pos [3];
    int      vel [3];
  } track_result_t;

  track_result_t result_q [$];

  // Shadow of the configuration registers.
  logic [16:0] cfg_dt;
  logic [23:0] cfg_qxy, cfg_qz, cfg_r, cfg_vmax;
  logic [15:0] cfg_plim, cfg_slim;

  // Shadow of the filter state.
  int          est_pos [3];
  int          est_vel [3];
  int          cov_pp [3];
  int          cov_pv [3];
  int          cov_vv [3];
  logic [15:0] ticks_idle;

  function automatic int clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return int'(x);
  endfunction

  // Floor of (x + 2^(n-1)) / 2^n.
  function automatic longint round_shift(longint x, int n);
    longint half;
    half = longint'(1) << (n - 1);
    return (x + half) >>> n;
  endfunction

  function automatic int qmul(int a, int b);
    return clamp32(round_shift(longint'(a) * longint'(b), 16));
  endfunction

  function automatic int qdiv(int num, int den);
    if (den <= 0) return 0;
    return clamp32((longint'(num) * 64'sd65536) / longint'(den));
  endfunction

  function automatic track_result_t snapshot(status_t st);
    track_result_t r;
    r.status = st;
    for (int a = 0; a < 3; a++) begin
      r.pos[a] = (a < AXES) ? est_pos[a] : 0;
      r.vel[a] = (a < AXES) ? est_vel[a] : 0;
    end
    return r;
  endfunction

  // Advance every axis over one step interval.
  task automatic predict_step();
    int dt, d2, d3, d4, q, pp, pv, vv;
    dt = int'({15'd0, cfg_dt});
    d2 = qmul(dt, dt);
    d3 = qmul(d2, dt);
    d4 = qmul(d2, d2);
    for (int a = 0; a < AXES; a++) begin
      q  = int'({8'd0, (a < 2) ? cfg_qxy : cfg_qz});
      pp = cov_pp[a];
      pv = cov_pv[a];
      vv = cov_vv[a];
      est_pos[a] = clamp32(longint'(est_pos[a]) + qmul(dt, est_vel[a]));
      cov_pp[a] = clamp32(longint'(pp) + 2 * longint'(qmul(dt, pv)) + qmul(d2, vv)
                          + round_shift(qmul(q, d4), 2));
      cov_pv[a] = clamp32(longint'(pv) + qmul(dt, vv) + round_shift(qmul(q, d3), 1));
      cov_vv[a] = clamp32(longint'(vv) + qmul(q, d2));
    end
  endtask

  // Restart, fuse or reject one position measurement.
  task automatic measure_step(int z [3], output track_result_t r);
    int          k0 [3], k1 [3], e [3], nv [3];
    int          s, rn, pp, pv, vv;
    logic [63:0] speed_sq, lim_sq;
    if (ticks_idle > cfg_slim) begin
      for (int a = 0; a < AXES; a++) begin
        est_pos[a] = z[a];
        est_vel[a] = 0;
        cov_pp[a] = 0;
        cov_pv[a] = 0;
        cov_vv[a] = 0;
      end
      ticks_idle = 16'd0;
      r = snapshot(ST_RESET);
      return;
    end
    rn = int'({8'd0, cfg_r});
    speed_sq = 64'd0;
    for (int a = 0; a < AXES; a++) begin
      s = clamp32(longint'(cov_pp[a]) + rn);
      k0[a] = qdiv(cov_pp[a], s);
      k1[a] = qdiv(cov_pv[a], s);
      e[a] = clamp32(longint'(z[a]) - est_pos[a]);
      nv[a] = clamp32(longint'(est_vel[a]) + qmul(k1[a], e[a]));
      speed_sq += 64'(longint'(nv[a]) * longint'(nv[a]));
    end
    lim_sq = 64'(cfg_vmax) * 64'(cfg_vmax);
    if (speed_sq > lim_sq) begin
      r = snapshot(ST_REJECTED);
      return;
    end
    for (int a = 0; a < AXES; a++) begin
      pp = cov_pp[a];
      pv = cov_pv[a];
      vv = cov_vv[a];
      est_pos[a] = clamp32(longint'(est_pos[a]) + qmul(k0[a], e[a]));
      est_vel[a] = nv[a];
      cov_pp[a] = clamp32(longint'(pp) - qmul(k0[a], pp));
      cov_pv[a] = clamp32(longint'(pv) - qmul(k0[a], pv));
      cov_vv[a] = clamp32(longint'(vv) - qmul(k1[a], pv));
    end
    ticks_idle = 16'd0;
    r = snapshot(ST_UPDATED);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
               $time, name, want, want, got, got);
    end
  endtask

  always @(posedge clk) begin
    track_result_t r;
    int            z [3];
    logic          go;
    if (rst) begin
      cfg_dt   = 17'd3277;
      cfg_qxy  = 24'd262144;
      cfg_qz   = 24'd65536;
      cfg_r    = 24'd6554;
      cfg_vmax = 24'd262144;
      cfg_plim = 16'd40;
      cfg_slim = 16'd60;
      for (int a = 0; a < 3; a++) begin
        est_pos[a] = 0;
        est_vel[a] = 0;
        cov_pp[a] = 0;
        cov_pv[a] = 0;
        cov_vv[a] = 0;
      end
      ticks_idle = 16'hFFFF;
      result_q.delete();
      errors = 0;
    end else begin
      // Register write transaction.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[cvkt_pkg::ADDR_W-1:2]))
          REG_STEP_TIME:     cfg_dt   = pwdata[16:0];
          REG_NOISE_XY:      cfg_qxy  = pwdata[23:0];
          REG_NOISE_Z:       cfg_qz   = pwdata[23:0];
          REG_MEAS_NOISE:    cfg_r    = pwdata[23:0];
          REG_SPEED_LIMIT:   cfg_vmax = pwdata[23:0];
          REG_PREDICT_LIMIT: cfg_plim = pwdata[15:0];
          REG_STALE_LIMIT:   cfg_slim = pwdata[15:0];
          default: ;
        endcase
      end

      // Input transaction: a tick or a measurement.
      if (mon_in.valid && mon_in.ready) begin
        if (!mon_in.kind) begin
          go = ticks_idle < cfg_plim;
          if (ticks_idle != 16'hFFFF) ticks_idle++;
          if (go) begin
            predict_step();
            result_q.push_back(snapshot(ST_PREDICTED));
          end
        end else begin
          z[0] = mon_in.meas_x;
          z[1] = mon_in.meas_y;
          z[2] = mon_in.meas_z;
          measure_step(z, r);
          result_q.push_back(r);
        end
      end

      // Result transaction.
      if (mon_out.valid && mon_out.ready) begin
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result with status %0d arrived with none expected",
                   $time, mon_out.status);
        end else begin
          r = result_q.pop_front();
          check_field("status", int'(r.status), int'(mon_out.status));
          check_field("pos_x", r.pos[0], mon_out.pos_x);
          check_field("pos_y", r.pos[1], mon_out.pos_y);
          check_field("pos_z", r.pos[2], mon_out.pos_z);
          check_field("vel_x", r.vel[0], mon_out.vel_x);
          check_field("vel_y", r.vel[1], mon_out.vel_y);
          check_field("vel_z", r.vel[2], mon_out.vel_z);
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// ===== tb/sv/const_velocity_kalman_tracker_core_tb.sv =====
module const_velocity_kalman_tracker_core_tb;
  import cvkt_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;
  int   errors, pending;
  logic in_fire;
  int   send_idle_pct, recv_stall_pct;
  int   quiet_cycles;
  int   trk [3];

  cvkt_in_if  meas_ch ();
  cvkt_out_if res_ch ();

  const_velocity_kalman_tracker_core dut (
    .clk(clk), .rst(rst), .meas_in(meas_ch), .result_out(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  cvkt_tracker_checker u_checker (
    .clk(clk), .rst(rst), .mon_in(meas_ch), .mon_out(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Acceptance of the input transaction at the last rising edge.
  always @(posedge clk) in_fire <= meas_ch.valid && meas_ch.ready;

  // Receiver back-pressure.
  always @(negedge clk) res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (meas_ch.valid && meas_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait for every expected result, then let any absorbed tick drain.
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic load_config(logic [31:0] dt, logic [31:0] qxy, logic [31:0] qz,
                             logic [31:0] r, logic [31:0] vmax, logic [31:0] plim,
                             logic [31:0] slim);
    wait_drained();
    reg_write(REG_STEP_TIME, dt);
    reg_write(REG_NOISE_XY, qxy);
    reg_write(REG_NOISE_Z, qz);
    reg_write(REG_MEAS_NOISE, r);
    reg_write(REG_SPEED_LIMIT, vmax);
    reg_write(REG_PREDICT_LIMIT, plim);
    reg_write(REG_STALE_LIMIT, slim);
  endtask

  // One input transaction, with optional idle cycles in front of it.
  task automatic send_item(logic kind, int x, int y, int z);
    while ($urandom_range(99) < send_idle_pct) begin
      meas_ch.valid <= 1'b0;
      @(negedge clk);
    end
    meas_ch.valid <= 1'b1;
    meas_ch.kind <= kind;
    meas_ch.meas_x <= x;
    meas_ch.meas_y <= y;
    meas_ch.meas_z <= z;
    do @(negedge clk); while (!in_fire);
  endtask

  task automatic send_tick();
    send_item(1'b0, $urandom, $urandom, $urandom);
  endtask

  function automatic int near_track(int base);
    return base + int'($urandom_range(0, 1 << 19)) - (1 << 18);
  endfunction

  function automatic int corner_value();
    case ($urandom_range(3))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // Random mix: measurements close to a drifting track, ticks, wild and corner-value
  // measurements, and occasional long tick runs that go late and stale.
  task automatic random_items(int count, bit hold_off);
    int sel, run;
    for (int i = 0; i < count; i++) begin
      if (hold_off && i == count / 2) begin
        meas_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      sel = $urandom_range(99);
      for (int a = 0; a < 3; a++) trk[a] += int'($urandom_range(0, 1 << 14)) - (1 << 13);
      if (sel < 40) begin
        send_tick();
      end else if (sel < 84) begin
        send_item(1'b1, near_track(trk[0]), near_track(trk[1]), near_track(trk[2]));
      end else if (sel < 92) begin
        for (int a = 0; a < 3; a++) trk[a] = $urandom;
        send_item(1'b1, trk[0], trk[1], trk[2]);
      end else if (sel < 97) begin
        send_item(1'b1, corner_value(), corner_value(), corner_value());
      end else begin
        run = $urandom_range(10, 80);
        repeat (run) send_tick();
      end
    end
    meas_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(int idle_mode, int count, bit hold_off);
    case (idle_mode)
      1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
      3: begin send_idle_pct = 21; recv_stall_pct = 21; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
    random_items(count, hold_off);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    meas_ch.valid = 1'b0;
    meas_ch.kind = 1'b0;
    meas_ch.meas_x = 0;
    meas_ch.meas_y = 0;
    meas_ch.meas_z = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    trk = '{0, 0, 0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: stale restart from reset at the extremes, prediction, fusion,
    // a gate rejection with saturating innovations, and zero input.
    send_item(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_tick();
    send_tick();
    send_tick();
    send_item(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_item(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, -1);
    send_item(1'b1, 0, 0, 0);
    send_tick();
    send_item(1'b1, 1 << 16, -(1 << 16), 1 << 15);
    send_tick();
    send_item(1'b1, 1 << 17, -(1 << 17), 1 << 16);
    send_tick();
    meas_ch.valid <= 1'b0;
    // Late ticks and a stale restart under tight limits.
    load_config(17'd65536, 24'hFF_FFFF, 24'hFF_FFFF, 24'd1, 24'd0, 32'd2, 32'd3);
    repeat (6) send_tick();
    send_item(1'b1, 5 << 16, 6 << 16, 7 << 16);
    send_tick();
    send_item(1'b1, 5 << 16, 6 << 16, 7 << 16);
    send_item(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    meas_ch.valid <= 1'b0;

    // Random phases across register settings and idling patterns.
    load_config(32'd3277, 32'd262144, 32'd65536, 32'd6554, 32'd262144, 32'd40, 32'd60);
    run_phase(0, 30, 1'b0);
    load_config(32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0);
    run_phase(1, 20, 1'b0);
    load_config(32'd65536, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF,
                32'hFFFF, 32'hFFFF);
    run_phase(2, 25, 1'b0);
    load_config(32'd6554, 32'd1 << 20, 32'd1 << 18, 32'd1 << 16, 32'hFF_FFFF,
                32'd8, 32'd12);
    run_phase(3, 30, 1'b1);
    load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(64),
                $urandom_range(64));
    run_phase(1, 25, 1'b0);
    load_config(32'd3277, 32'd262144, 32'd65536, 32'd655, 32'd1 << 20, 32'd5, 32'd3);
    run_phase(2, 25, 1'b0);
    load_config($urandom_range(1, 65536), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    run_phase(3, 25, 1'b0);
    load_config(32'd3277, 32'd262144, 32'd65536, 32'd6554, 32'd262144, 32'd40, 32'd60);
    run_phase(0, 20, 1'b0);

    wait_drained();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
